/* rtl/q2e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, CORDIC arctangent table and cell data types.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int OPW        = 36;   // atan2 operand width, 1.0 = 2**30
    localparam int ACCW       = 34;   // angle accumulator, pi = 2**31
    localparam int SQW        = 62;   // square root remainder width
    localparam int SQRT_STEPS = 31;   // one result bit per cell
    localparam int TAB_LEN    = 24;

    typedef logic [31:0] t_tab [TAB_LEN];

    localparam t_tab ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                   zero;
        logic signed [OPW-1:0]  x;
        logic signed [OPW-1:0]  y;
        logic signed [ACCW-1:0] acc;
    } t_cordic;

    typedef struct packed {
        logic [SQW-1:0]        n;
        logic [SQW-1:0]        r;
        logic signed [OPW-1:0] sp;
    } t_sqrt;

endpackage

/* rtl/q2e_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell import q2e_pkg::*; #(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_d,
    output t_sqrt o_q
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    t_sqrt          r_q;
    t_sqrt          n_q;
    logic [SQW-1:0] trial;

    always_comb begin
        trial = i_d.r + BIT;
        n_q   = i_d;
        if (i_d.n >= trial) begin
            n_q.n = i_d.n - trial;
            n_q.r = (i_d.r >> 1) + BIT;
        end else begin
            n_q.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/q2e_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring micro-rotation of the CORDIC chain, registered.
// ----------------------------------------------------------------------------
module q2e_cordic_cell import q2e_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_q
);

    localparam logic signed [ACCW-1:0] ANG = ACCW'(ATAN_TAB[STEP]);

    t_cordic               r_q;
    t_cordic               n_q;
    logic signed [OPW-1:0] xs;
    logic signed [OPW-1:0] ys;

    always_comb begin
        xs = i_d.x >>> STEP;
        ys = i_d.y >>> STEP;
        n_q = i_d;
        if (i_d.y > 0) begin
            n_q.x   = i_d.x + ys;
            n_q.y   = i_d.y - xs;
            n_q.acc = i_d.acc + ANG;
        end else begin
            n_q.x   = i_d.x - ys;
            n_q.y   = i_d.y + xs;
            n_q.acc = i_d.acc - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion in Q1.15 to roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// The block accepts one quaternion per clock while the output is not stalled
// and returns one result per transaction, in order. Its pipeline stages are
// five arithmetic stages, a 31-cell square root chain for the pitch cosine,
// one pre-rotation stage, CORDIC_STEPS cells per angle and the output
// register. The whole pipeline holds only while a finished result waits at
// the output, so a transaction can be taken in every cycle in which none waits.
module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle
);

    localparam int DLY  = SQRT_STEPS + 2;
    localparam int NSTG = 6 + SQRT_STEPS + CORDIC_STEPS + 1;
    localparam logic signed [OPW-1:0] ONE = OPW'(1) <<< 30;
    localparam logic signed [OPW-1:0] NEG_ONE = -ONE;
    localparam logic signed [ACCW-1:0] QUARTER = ACCW'(1) <<< 30;
    localparam logic signed [17:0] PMAX = 18'sd16384;
    localparam logic signed [17:0] PMIN = -18'sd16384;

    typedef struct packed {
        logic signed [OPW-1:0] sr;
        logic signed [OPW-1:0] cr;
        logic signed [OPW-1:0] sy;
        logic signed [OPW-1:0] cy;
    } t_lanes;

    logic en;
    logic [NSTG-1:0] r_vld;

    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic signed [31:0] r_xw, r_yz, r_xx, r_yy, r_yw, r_xz, r_xy, r_zw, r_zz;
    t_lanes                r_lane;
    t_lanes                n_lane;
    logic signed [OPW-1:0] r_sp;
    logic signed [OPW-1:0] n_sp;
    logic [SQW-1:0]        r_sq;
    logic signed [OPW-1:0] r_sp_d;
    t_sqrt                 r_sqin;
    t_lanes                r_dly [DLY];
    t_sqrt                 s_chain [SQRT_STEPS+1];
    t_cordic               r_roll_in;
    t_cordic               r_pitch_in;
    t_cordic               r_yaw_in;
    t_cordic               c_roll  [CORDIC_STEPS+1];
    t_cordic               c_pitch [CORDIC_STEPS+1];
    t_cordic               c_yaw   [CORDIC_STEPS+1];
    logic signed [63:0]    sp_sq;
    logic signed [17:0]    a_roll, a_pitch, a_yaw;
    logic signed [15:0]    r_roll, r_pitch, r_yaw;
    logic signed [15:0]    n_pitch;

    function automatic t_cordic prep(input logic signed [OPW-1:0] y,
                                     input logic signed [OPW-1:0] x);
        t_cordic c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.acc  = '0;
        if (x < 0) begin
            if (y >= 0) begin
                c.x   = y;
                c.y   = -x;
                c.acc = QUARTER;
            end else begin
                c.x   = -y;
                c.y   = x;
                c.acc = -QUARTER;
            end
        end
        return c;
    endfunction

    function automatic logic signed [17:0] finish(input t_cordic c);
        logic signed [ACCW-1:0] t;
        t = c.acc + ACCW'(32768);
        return c.zero ? 18'sd0 : 18'(t >>> 16);
    endfunction

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        n_lane.sr = ((OPW'(r_xw) + OPW'(r_yz)) <<< 1);
        n_lane.cr = ONE - ((OPW'(r_xx) + OPW'(r_yy)) <<< 1);
        n_lane.sy = ((OPW'(r_xy) + OPW'(r_zw)) <<< 1);
        n_lane.cy = ONE - ((OPW'(r_yy) + OPW'(r_zz)) <<< 1);
        n_sp = ((OPW'(r_yw) - OPW'(r_xz)) <<< 1);
        if (n_sp > ONE) begin
            n_sp = ONE;
        end else if (n_sp < NEG_ONE) begin
            n_sp = NEG_ONE;
        end
    end

    // The clamped sine fits in 32 bits, so its square is one 32x32 product.
    assign sp_sq = $signed(r_sp[31:0]) * $signed(r_sp[31:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x  <= i_quat_x;
            r_y  <= i_quat_y;
            r_z  <= i_quat_z;
            r_w  <= i_quat_w;
            r_xw <= r_x * r_w;
            r_yz <= r_y * r_z;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_yw <= r_y * r_w;
            r_xz <= r_x * r_z;
            r_xy <= r_x * r_y;
            r_zw <= r_z * r_w;
            r_zz <= r_z * r_z;
            r_lane <= n_lane;
            r_sp   <= n_sp;
            r_sq   <= sp_sq[SQW-1:0];
            r_sp_d <= r_sp;
            r_sqin.n  <= (SQW'(1) << 60) - r_sq;
            r_sqin.r  <= '0;
            r_sqin.sp <= r_sp_d;
            r_dly[0]  <= r_lane;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign s_chain[0] = r_sqin;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        q2e_sqrt_cell #(.K(SQRT_STEPS - 1 - g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (s_chain[g]),
            .o_q   (s_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll_in  <= prep(r_dly[DLY-1].sr, r_dly[DLY-1].cr);
            r_pitch_in <= prep(s_chain[SQRT_STEPS].sp,
                               OPW'(s_chain[SQRT_STEPS].r));
            r_yaw_in   <= prep(r_dly[DLY-1].sy, r_dly[DLY-1].cy);
        end
    end

    assign c_roll[0]  = r_roll_in;
    assign c_pitch[0] = r_pitch_in;
    assign c_yaw[0]   = r_yaw_in;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        q2e_cordic_cell #(.STEP(g)) u_roll (
            .i_clk (i_clk), .i_en (en), .i_d (c_roll[g]),  .o_q (c_roll[g+1])
        );
        q2e_cordic_cell #(.STEP(g)) u_pitch (
            .i_clk (i_clk), .i_en (en), .i_d (c_pitch[g]), .o_q (c_pitch[g+1])
        );
        q2e_cordic_cell #(.STEP(g)) u_yaw (
            .i_clk (i_clk), .i_en (en), .i_d (c_yaw[g]),   .o_q (c_yaw[g+1])
        );
    end

    assign a_roll  = finish(c_roll[CORDIC_STEPS]);
    assign a_pitch = finish(c_pitch[CORDIC_STEPS]);
    assign a_yaw   = finish(c_yaw[CORDIC_STEPS]);

    always_comb begin
        if (a_pitch > PMAX) begin
            n_pitch = 16'(PMAX);
        end else if (a_pitch < PMIN) begin
            n_pitch = 16'(PMIN);
        end else begin
            n_pitch = a_pitch[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= a_roll[15:0];
            r_pitch <= n_pitch;
            r_yaw   <= a_yaw[15:0];
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;
    assign o_yaw_angle   = r_yaw;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 16'sd16384) && (o_pitch_angle >= -16'sd16384))
        else $error("pitch angle outside a quarter turn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow the output stall");

endmodule
